[rtl/core/wsa_pkg.sv]
// Shared types, constants and lookup functions of the weather station aggregator.
`default_nettype none

package wsa_pkg;

  // Sizes of the data path
  localparam int SECTIONS    = 7;
  localparam int DIRS        = 4;
  localparam int COUNT_BITS  = 16;
  localparam int HIST_BITS   = 16;
  localparam int SAMPLE_BITS = 10;
  localparam int GAIN_BITS   = 10;
  localparam int FACTOR_BITS = 21;
  localparam int ERR_BITS    = 41;
  localparam int CHG_BITS    = 16;
  localparam int PRODUCT_OUT_BITS = 26;
  localparam int SEC_BITS    = $clog2(SECTIONS);
  localparam int DIR_BITS    = $clog2(DIRS);
  localparam int MUL_A_BITS  = (COUNT_BITS > HIST_BITS) ? COUNT_BITS : HIST_BITS;
  localparam int MUL_P_BITS  = MUL_A_BITS + FACTOR_BITS;

  // Configuration port
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIND_GAIN = 2'd1;
  localparam logic [1:0] REG_RAIN_GAIN = 2'd2;

  localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = 10'd350;
  localparam logic [GAIN_BITS-1:0]   WIND_GAIN_RESET = 10'd205;
  localparam logic [GAIN_BITS-1:0]   RAIN_GAIN_RESET = 10'd280;

  // Item operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLOSE  = 1'b1;

  // Sequencer states
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SAMPLE = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_ACC    = 7'b0001000,
    S_WMUL   = 7'b0010000,
    S_RMUL   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  // Decoded vane reading
  typedef struct packed {
    logic                hit;
    logic [SEC_BITS-1:0] sec;
  } vane_sec_t;

  // Map a vane code to its section; codes outside the table miss
  function automatic vane_sec_t decode_vane(input logic [SAMPLE_BITS-1:0] code);
    vane_sec_t r;
    r.hit = 1'b1;
    r.sec = '0;
    if (code >= 10'd550 && code <= 10'd552)      r.sec = 3'd4;
    else if (code >= 10'd608 && code <= 10'd610) r.sec = 3'd3;
    else if (code >= 10'd634 && code <= 10'd636) r.sec = 3'd2;
    else if (code >= 10'd652 && code <= 10'd654) r.sec = 3'd5;
    else if (code >= 10'd661 && code <= 10'd663) r.sec = 3'd1;
    else if (code >= 10'd665 && code <= 10'd667) r.sec = 3'd6;
    else if (code >= 10'd668 && code <= 10'd670) r.sec = 3'd0;
    else r.hit = 1'b0;
    return r;
  endfunction

  // Weighted squared angular distance, scaled by 64, per direction and section
  function automatic logic [FACTOR_BITS-1:0] factor(input logic [DIR_BITS-1:0] d,
                                                    input logic [SEC_BITS-1:0] s);
    logic [FACTOR_BITS-1:0] f;
    unique case ({d, s})
      5'd0:  f = 21'd2673;
      5'd1:  f = 21'd64800;
      5'd2:  f = 21'd259200;
      5'd3:  f = 21'd583200;
      5'd4:  f = 21'd1822500;
      5'd5:  f = 21'd291600;
      5'd6:  f = 21'd96228;
      5'd8:  f = 21'd216513;
      5'd9:  f = 21'd64800;
      5'd10: f = 21'd0;
      5'd11: f = 21'd64800;
      5'd12: f = 21'd396900;
      5'd13: f = 21'd291600;
      5'd14: f = 21'd523908;
      5'd16: f = 21'd601425;
      5'd17: f = 21'd583200;
      5'd18: f = 21'd259200;
      5'd19: f = 21'd64800;
      5'd20: f = 21'd8100;
      5'd21: f = 21'd32400;
      5'd22: f = 21'd267300;
      5'd24: f = 21'd130977;
      5'd25: f = 21'd1620000;
      5'd26: f = 21'd1036800;
      5'd27: f = 21'd583200;
      5'd28: f = 21'd656100;
      5'd29: f = 21'd32400;
      5'd30: f = 21'd10692;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

[rtl/core/weather_station_sensor_aggregator_unit.sv]
// Top level of the weather station aggregator: level counters, vane histogram, direction pick, gain products.
`default_nettype none

// A sample item (op 0) is taken in the idle state and processed in the next
// one, with input stalled meanwhile. A close item (op 1) runs 28
// histogram-by-factor products through one shared multiplier, each as a
// multiply step and then an accumulate step (compared with the best at the
// end of a direction), then two more products for the gains and a final
// step that loads the result once a previous result, if any, is taken. Sample
// items are accepted while a result waits to be taken. Registers sit at byte
// addresses 0 (level threshold), 4 (wind gain) and 8 (rain gain); write them
// only while the block is idle.
module weather_station_sensor_aggregator_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input items
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_op,
  input  wire logic [wsa_pkg::SAMPLE_BITS-1:0]      in_wind_sample,
  input  wire logic [wsa_pkg::SAMPLE_BITS-1:0]      in_rain_sample,
  input  wire logic [wsa_pkg::SAMPLE_BITS-1:0]      in_vane_sample,
  // result items
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [wsa_pkg::CHG_BITS-1:0]              out_wind_changes,
  output logic [wsa_pkg::CHG_BITS-1:0]              out_rain_changes,
  output logic [wsa_pkg::PRODUCT_OUT_BITS-1:0]      out_wind_speed,
  output logic [wsa_pkg::PRODUCT_OUT_BITS-1:0]      out_rain_rate,
  output logic [wsa_pkg::DIR_BITS-1:0]              out_direction,
  // configuration
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [wsa_pkg::ADDR_BITS-1:0]        paddr,
  input  wire logic [wsa_pkg::DATA_BITS-1:0]        pwdata,
  output logic [wsa_pkg::DATA_BITS-1:0]             prdata,
  output logic                                      pready
);

  localparam logic [wsa_pkg::SEC_BITS-1:0] LAST_SEC = wsa_pkg::SEC_BITS'(wsa_pkg::SECTIONS - 1);
  localparam logic [wsa_pkg::DIR_BITS-1:0] LAST_DIR = wsa_pkg::DIR_BITS'(wsa_pkg::DIRS - 1);

  wsa_pkg::state_t state_r, state_nxt;

  logic [wsa_pkg::SAMPLE_BITS-1:0] thr_r, thr_nxt;
  logic [wsa_pkg::GAIN_BITS-1:0]   wgain_r, wgain_nxt;
  logic [wsa_pkg::GAIN_BITS-1:0]   rgain_r, rgain_nxt;

  logic [wsa_pkg::SAMPLE_BITS-1:0] wsmp_r, wsmp_nxt;
  logic [wsa_pkg::SAMPLE_BITS-1:0] rsmp_r, rsmp_nxt;
  logic [wsa_pkg::SAMPLE_BITS-1:0] vsmp_r, vsmp_nxt;

  logic                            wprev_r, wprev_nxt;
  logic                            rprev_r, rprev_nxt;
  logic [wsa_pkg::COUNT_BITS-1:0]  wcnt_r, wcnt_nxt;
  logic [wsa_pkg::COUNT_BITS-1:0]  rcnt_r, rcnt_nxt;
  logic [wsa_pkg::HIST_BITS-1:0]   hist_r   [wsa_pkg::SECTIONS];
  logic [wsa_pkg::HIST_BITS-1:0]   hist_nxt [wsa_pkg::SECTIONS];

  logic [wsa_pkg::SEC_BITS-1:0]    sec_r, sec_nxt;
  logic [wsa_pkg::DIR_BITS-1:0]    dir_r, dir_nxt;
  logic [wsa_pkg::ERR_BITS-1:0]    acc_r, acc_nxt;
  logic [wsa_pkg::ERR_BITS-1:0]    best_r, best_nxt;
  logic [wsa_pkg::DIR_BITS-1:0]    bdir_r, bdir_nxt;
  logic [wsa_pkg::MUL_P_BITS-1:0]  prod_r, prod_nxt;
  logic [wsa_pkg::PRODUCT_OUT_BITS-1:0] speed_r, speed_nxt;

  logic                                  ovalid_r, ovalid_nxt;
  logic [wsa_pkg::CHG_BITS-1:0]          owchg_r, owchg_nxt;
  logic [wsa_pkg::CHG_BITS-1:0]          orchg_r, orchg_nxt;
  logic [wsa_pkg::PRODUCT_OUT_BITS-1:0]  ospeed_r, ospeed_nxt;
  logic [wsa_pkg::PRODUCT_OUT_BITS-1:0]  orate_r, orate_nxt;
  logic [wsa_pkg::DIR_BITS-1:0]          odir_r, odir_nxt;

  logic                            in_acc;
  logic                            cfg_wr;
  logic [1:0]                      cfg_idx;
  logic                            out_free;
  wsa_pkg::vane_sec_t              vane;
  logic                            wlvl, rlvl;
  logic [wsa_pkg::MUL_A_BITS-1:0]  mul_a;
  logic [wsa_pkg::FACTOR_BITS-1:0] mul_b;
  logic [wsa_pkg::ERR_BITS-1:0]    acc_sum;
  logic [wsa_pkg::MUL_A_BITS-1:0]  wcnt_ext, rcnt_ext;

  // Handshake and register decode
  assign in_stall = (state_r != wsa_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !ovalid_r || !out_stall;
  assign pready   = 1'b1;
  assign cfg_idx  = paddr[3:2];
  assign cfg_wr   = psel && penable && pwrite && pready;

  assign out_valid        = ovalid_r;
  assign out_wind_changes = owchg_r;
  assign out_rain_changes = orchg_r;
  assign out_wind_speed   = ospeed_r;
  assign out_rain_rate    = orate_r;
  assign out_direction    = odir_r;

  // Read back registers
  always_comb begin
    unique case (cfg_idx)
      wsa_pkg::REG_THRESHOLD: prdata = wsa_pkg::DATA_BITS'(thr_r);
      wsa_pkg::REG_WIND_GAIN: prdata = wsa_pkg::DATA_BITS'(wgain_r);
      wsa_pkg::REG_RAIN_GAIN: prdata = wsa_pkg::DATA_BITS'(rgain_r);
      default:                prdata = '0;
    endcase
  end

  // Write registers
  always_comb begin
    thr_nxt   = thr_r;
    wgain_nxt = wgain_r;
    rgain_nxt = rgain_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        wsa_pkg::REG_THRESHOLD: thr_nxt   = pwdata[wsa_pkg::SAMPLE_BITS-1:0];
        wsa_pkg::REG_WIND_GAIN: wgain_nxt = pwdata[wsa_pkg::GAIN_BITS-1:0];
        wsa_pkg::REG_RAIN_GAIN: rgain_nxt = pwdata[wsa_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operand select
  assign wcnt_ext = wsa_pkg::MUL_A_BITS'(wcnt_r);
  assign rcnt_ext = wsa_pkg::MUL_A_BITS'(rcnt_r);

  always_comb begin
    unique case (state_r)
      wsa_pkg::S_WMUL: begin
        mul_a = wcnt_ext;
        mul_b = wsa_pkg::FACTOR_BITS'(wgain_r);
      end
      wsa_pkg::S_RMUL: begin
        mul_a = rcnt_ext;
        mul_b = wsa_pkg::FACTOR_BITS'(rgain_r);
      end
      default: begin
        mul_a = wsa_pkg::MUL_A_BITS'(hist_r[sec_r]);
        mul_b = wsa_pkg::factor(dir_r, sec_r);
      end
    endcase
  end

  assign vane    = wsa_pkg::decode_vane(vsmp_r);
  assign wlvl    = (wsmp_r > thr_r);
  assign rlvl    = (rsmp_r > thr_r);
  assign acc_sum = acc_r +
                   wsa_pkg::ERR_BITS'(prod_r[wsa_pkg::HIST_BITS+wsa_pkg::FACTOR_BITS-1:0]);

  // Sequencer and data path
  always_comb begin
    state_nxt  = state_r;
    wsmp_nxt   = wsmp_r;
    rsmp_nxt   = rsmp_r;
    vsmp_nxt   = vsmp_r;
    wprev_nxt  = wprev_r;
    rprev_nxt  = rprev_r;
    wcnt_nxt   = wcnt_r;
    rcnt_nxt   = rcnt_r;
    for (int k = 0; k < wsa_pkg::SECTIONS; k++) hist_nxt[k] = hist_r[k];
    sec_nxt    = sec_r;
    dir_nxt    = dir_r;
    acc_nxt    = acc_r;
    best_nxt   = best_r;
    bdir_nxt   = bdir_r;
    prod_nxt   = prod_r;
    speed_nxt  = speed_r;
    ovalid_nxt = ovalid_r && out_stall;
    owchg_nxt  = owchg_r;
    orchg_nxt  = orchg_r;
    ospeed_nxt = ospeed_r;
    orate_nxt  = orate_r;
    odir_nxt   = odir_r;

    unique case (state_r)
      // Take an item
      wsa_pkg::S_IDLE: begin
        if (in_acc) begin
          wsmp_nxt = in_wind_sample;
          rsmp_nxt = in_rain_sample;
          vsmp_nxt = in_vane_sample;
          sec_nxt  = '0;
          dir_nxt  = '0;
          acc_nxt  = '0;
          if (in_op == wsa_pkg::OP_CLOSE) state_nxt = wsa_pkg::S_MUL;
          else                            state_nxt = wsa_pkg::S_SAMPLE;
        end
      end
      // Count level changes and bin the vane section
      wsa_pkg::S_SAMPLE: begin
        if (wlvl != wprev_r) begin
          wprev_nxt = wlvl;
          if (wcnt_r != '1) wcnt_nxt = wcnt_r + 1'b1;
        end
        if (rlvl != rprev_r) begin
          rprev_nxt = rlvl;
          if (rcnt_r != '1) rcnt_nxt = rcnt_r + 1'b1;
        end
        for (int k = 0; k < wsa_pkg::SECTIONS; k++) begin
          if (vane.hit && vane.sec == wsa_pkg::SEC_BITS'(k) && hist_r[k] != '1)
            hist_nxt[k] = hist_r[k] + 1'b1;
        end
        state_nxt = wsa_pkg::S_IDLE;
      end
      // Multiply one bin by its factor
      wsa_pkg::S_MUL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = wsa_pkg::S_ACC;
      end
      // Accumulate; at the end of a direction compare with the best so far
      wsa_pkg::S_ACC: begin
        acc_nxt = acc_sum;
        sec_nxt = sec_r + 1'b1;
        state_nxt = wsa_pkg::S_MUL;
        if (sec_r == LAST_SEC) begin
          acc_nxt = '0;
          sec_nxt = '0;
          dir_nxt = dir_r + 1'b1;
          if (dir_r == '0 || acc_sum < best_r) begin
            best_nxt = acc_sum;
            bdir_nxt = dir_r;
          end
          if (dir_r == LAST_DIR) state_nxt = wsa_pkg::S_WMUL;
        end
      end
      // Wind gain product
      wsa_pkg::S_WMUL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = wsa_pkg::S_RMUL;
      end
      // Rain gain product; keep the wind product
      wsa_pkg::S_RMUL: begin
        speed_nxt = prod_r[wsa_pkg::PRODUCT_OUT_BITS-1:0];
        prod_nxt  = mul_a * mul_b;
        state_nxt = wsa_pkg::S_FINISH;
      end
      // Load the result once the output is free, then clear the interval
      wsa_pkg::S_FINISH: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          owchg_nxt  = wcnt_ext[wsa_pkg::CHG_BITS-1:0];
          orchg_nxt  = rcnt_ext[wsa_pkg::CHG_BITS-1:0];
          ospeed_nxt = speed_r;
          orate_nxt  = prod_r[wsa_pkg::PRODUCT_OUT_BITS-1:0];
          odir_nxt   = bdir_r;
          wcnt_nxt   = '0;
          rcnt_nxt   = '0;
          for (int k = 0; k < wsa_pkg::SECTIONS; k++) hist_nxt[k] = '0;
          state_nxt  = wsa_pkg::S_IDLE;
        end
      end
      default: state_nxt = wsa_pkg::S_IDLE;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= wsa_pkg::S_IDLE;
      thr_r    <= wsa_pkg::THRESHOLD_RESET;
      wgain_r  <= wsa_pkg::WIND_GAIN_RESET;
      rgain_r  <= wsa_pkg::RAIN_GAIN_RESET;
      wprev_r  <= 1'b0;
      rprev_r  <= 1'b0;
      wcnt_r   <= '0;
      rcnt_r   <= '0;
      for (int k = 0; k < wsa_pkg::SECTIONS; k++) hist_r[k] <= '0;
      sec_r    <= '0;
      dir_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      thr_r    <= thr_nxt;
      wgain_r  <= wgain_nxt;
      rgain_r  <= rgain_nxt;
      wprev_r  <= wprev_nxt;
      rprev_r  <= rprev_nxt;
      wcnt_r   <= wcnt_nxt;
      rcnt_r   <= rcnt_nxt;
      for (int k = 0; k < wsa_pkg::SECTIONS; k++) hist_r[k] <= hist_nxt[k];
      sec_r    <= sec_nxt;
      dir_r    <= dir_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wsmp_r   <= wsmp_nxt;
    rsmp_r   <= rsmp_nxt;
    vsmp_r   <= vsmp_nxt;
    acc_r    <= acc_nxt;
    best_r   <= best_nxt;
    bdir_r   <= bdir_nxt;
    prod_r   <= prod_nxt;
    speed_r  <= speed_nxt;
    owchg_r  <= owchg_nxt;
    orchg_r  <= orchg_nxt;
    ospeed_r <= ospeed_nxt;
    orate_r  <= orate_nxt;
    odir_r   <= odir_nxt;
  end

`ifndef SYNTHESIS
  // A new result only comes out of the final step
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(state_r == wsa_pkg::S_FINISH))
    else $error("result raised outside the final step");

  // Closing an interval clears both counters and the first and last histogram bins
  a_interval_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wsa_pkg::S_FINISH && out_free) |=>
      (wcnt_r == '0 && rcnt_r == '0 && hist_r[0] == '0 && hist_r[LAST_SEC] == '0))
    else $error("interval state not cleared at close");

  // A close item starts the product walk at its first entry
  a_close_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_op == wsa_pkg::OP_CLOSE) |=>
      (state_r == wsa_pkg::S_MUL && sec_r == '0 && dir_r == '0 && acc_r == '0))
    else $error("close item did not start the product walk");

  // The section index never leaves the histogram
  a_sec_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    sec_r <= LAST_SEC)
    else $error("section index out of range");
`endif

endmodule

`default_nettype wire
